[rtl/core/bams_pkg.sv]
package bams_pkg;

   // motor action codes
   localparam logic [1:0] ACT_RELEASE = 2'd0;
   localparam logic [1:0] ACT_RUN     = 2'd1;
   localparam logic [1:0] ACT_BRAKE   = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_HOLD_TICKS = 2'd0;
   localparam logic [1:0] CSR_TILT_HIGH  = 2'd1;
   localparam logic [1:0] CSR_TILT_LOW   = 2'd2;

   localparam int CSR_DATA_WIDTH = 16;
   localparam int TILT_WIDTH     = 15;
   localparam int PITCH_WIDTH    = 16;

   localparam logic [15:0] HOLD_TICKS_RESET = 16'd500;
   localparam logic [14:0] TILT_HIGH_RESET  = 15'd300;
   localparam logic [14:0] TILT_LOW_RESET   = 15'd50;

   typedef struct packed {
      logic [15:0] hold_ticks;
      logic [14:0] tilt_engage_high;
      logic [14:0] tilt_engage_low;
   } cfg_type;

   typedef struct packed {
      logic [1:0] motor_action;
      logic       control_enabled;
      logic       balancing_active;
      logic       arm_ready;
      logic       arm_stage;
      logic       brake_active;
      logic       clear_control_vars;
   } result_type;

endpackage

[rtl/core/bams_csr.sv]
module bams_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [1:0]                           csr_index,
   input  logic [bams_pkg::CSR_DATA_WIDTH-1:0] csr_wdata,
   output bams_pkg::cfg_type                    cfg
);
   import bams_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HOLD_TICKS: cfg_in.hold_ticks       = csr_wdata;
            CSR_TILT_HIGH:  cfg_in.tilt_engage_high = csr_wdata[TILT_WIDTH-1:0];
            CSR_TILT_LOW:   cfg_in.tilt_engage_low  = csr_wdata[TILT_WIDTH-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_ticks       <= HOLD_TICKS_RESET;
         cfg_ff.tilt_engage_high <= TILT_HIGH_RESET;
         cfg_ff.tilt_engage_low  <= TILT_LOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/bams_core.sv]
module bams_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      step,
   input  logic                                      button_c,
   input  logic                                      button_z,
   input  logic signed [bams_pkg::PITCH_WIDTH-1:0]  pitch_angle,
   input  bams_pkg::cfg_type                         cfg,
   output bams_pkg::result_type                      result
);
   import bams_pkg::*;

   localparam int CMP_WIDTH = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

   logic [COUNT_WIDTH-1:0] c_cnt_ff, c_cnt_in, c_cnt_inc;
   logic [COUNT_WIDTH-1:0] z_cnt_ff, z_cnt_in, z_cnt_inc;
   logic c_held_ff, c_held_in;
   logic z_held_ff, z_held_in;
   logic enabled_ff, enabled_in;
   logic cleared_ff, cleared_in;
   logic armed_ff, armed_in;
   logic stage_ff, stage_in;
   logic balance_ff, balance_in;
   logic clr;
   logic [1:0] action;
   logic [PITCH_WIDTH-1:0] pitch_u;
   logic [PITCH_WIDTH:0]   mag;

   assign pitch_u = pitch_angle;
   // magnitude one bit wider so the most negative pitch fits
   assign mag = pitch_u[PITCH_WIDTH-1] ? ({1'b0, ~pitch_u} + (PITCH_WIDTH+1)'(1))
                                        : {1'b0, pitch_u};

   // saturating press counters, frozen once a hold is seen
   assign c_cnt_inc = (!c_held_ff && (c_cnt_ff != '1)) ? c_cnt_ff + COUNT_WIDTH'(1) : c_cnt_ff;
   assign z_cnt_inc = (!z_held_ff && (z_cnt_ff != '1)) ? z_cnt_ff + COUNT_WIDTH'(1) : z_cnt_ff;

   always_comb begin
      c_cnt_in   = c_cnt_ff;
      z_cnt_in   = z_cnt_ff;
      c_held_in  = c_held_ff;
      z_held_in  = z_held_ff;
      enabled_in = enabled_ff;
      cleared_in = cleared_ff;
      armed_in   = armed_ff;
      stage_in   = stage_ff;
      balance_in = balance_ff;
      clr        = 1'b0;
      action     = ACT_RELEASE;

      // button c: click enables, hold arms
      if (!button_c) begin
         c_held_in = 1'b0;
         c_cnt_in  = '0;
      end else begin
         c_cnt_in = c_cnt_inc;
         if (c_cnt_inc == COUNT_WIDTH'(1)) begin
            enabled_in = 1'b1;
            cleared_in = 1'b0;
         end
         if (CMP_WIDTH'(c_cnt_inc) >= CMP_WIDTH'(cfg.hold_ticks)) begin
            c_held_in = 1'b1;
            if (!balance_ff) armed_in = 1'b1;
            c_cnt_in = '0;
         end
      end

      // button z: click cancels balancing
      if (!button_z) begin
         z_held_in = 1'b0;
         z_cnt_in  = '0;
      end else begin
         z_cnt_in = z_cnt_inc;
         if (z_cnt_inc == COUNT_WIDTH'(1)) begin
            balance_in = 1'b0;
            armed_in   = 1'b0;
            stage_in   = 1'b0;
         end
         if (CMP_WIDTH'(z_cnt_inc) >= CMP_WIDTH'(cfg.hold_ticks)) z_held_in = 1'b1;
      end

      // both buttons: switch off
      if (button_c && button_z) begin
         enabled_in = 1'b0;
         balance_in = 1'b0;
         armed_in   = 1'b0;
         stage_in   = 1'b0;
         if (!cleared_in) begin
            cleared_in = 1'b1;
            clr        = 1'b1;
         end
      end

      // tilt sequence: out past high, then back inside low
      if (armed_in && !balance_in) begin
         if (!stage_in) begin
            if (mag >= {2'b00, cfg.tilt_engage_high}) stage_in = 1'b1;
         end else if (mag <= {2'b00, cfg.tilt_engage_low}) begin
            stage_in   = 1'b0;
            armed_in   = 1'b0;
            balance_in = 1'b1;
         end
      end

      if (enabled_in) begin
         if (!button_z) begin
            action = ACT_RUN;
         end else begin
            action     = ACT_BRAKE;
            balance_in = 1'b0;
            armed_in   = 1'b0;
            stage_in   = 1'b0;
            if (!cleared_in) begin
               cleared_in = 1'b1;
               clr        = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_cnt_ff   <= '0;
         z_cnt_ff   <= '0;
         c_held_ff  <= 1'b0;
         z_held_ff  <= 1'b0;
         enabled_ff <= 1'b0;
         cleared_ff <= 1'b0;
         armed_ff   <= 1'b0;
         stage_ff   <= 1'b0;
         balance_ff <= 1'b0;
      end else if (step) begin
         c_cnt_ff   <= c_cnt_in;
         z_cnt_ff   <= z_cnt_in;
         c_held_ff  <= c_held_in;
         z_held_ff  <= z_held_in;
         enabled_ff <= enabled_in;
         cleared_ff <= cleared_in;
         armed_ff   <= armed_in;
         stage_ff   <= stage_in;
         balance_ff <= balance_in;
      end
   end

   always_comb begin
      result.motor_action       = action;
      result.control_enabled    = enabled_in;
      result.balancing_active   = balance_in;
      result.arm_ready          = armed_in;
      result.arm_stage          = stage_in;
      result.brake_active       = button_z;
      result.clear_control_vars = clr;
   end

endmodule

[rtl/core/balance_arming_mode_sequencer.sv]
// Balance arming mode sequencer: one transfer on req_ per control tick (buttons c and z plus
// pitch in 0.01 degree units) gives one transfer on rsp_ with the motor action and mode flags.
// Throughput is one tick per clock cycle while rsp_stall is low; a result passes through the
// input register, then the result register, before it is on rsp_. The rate is set by the mode
// state in bams_core, which is read and rewritten once for each tick as it leaves the input
// register.
// req_stall rises only when the input register is full and the result register is held by
// rsp_stall. Configuration writes (csr_, always ready) take effect on the next cycle and are
// meant for an idle block; index 0 hold_ticks, 1 tilt_engage_high, 2 tilt_engage_low, other
// indexes are ignored.
module balance_arming_mode_sequencer #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // request channel
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_button_c,
   input  logic                                     req_button_z,
   input  logic signed [bams_pkg::PITCH_WIDTH-1:0] req_pitch_angle,
   // result channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [1:0]                               rsp_motor_action,
   output logic                                     rsp_control_enabled,
   output logic                                     rsp_balancing_active,
   output logic                                     rsp_arm_ready,
   output logic                                     rsp_arm_stage,
   output logic                                     rsp_brake_active,
   output logic                                     rsp_clear_control_vars,
   // register write port
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [1:0]                               csr_index,
   input  logic [bams_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import bams_pkg::*;

   cfg_type    cfg;
   result_type result;

   // input register
   logic                          in_valid_ff, in_valid_in;
   logic                          in_c_ff, in_z_ff;
   logic signed [PITCH_WIDTH-1:0] in_pitch_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   logic advance;     // tick moves from input register to result register
   logic req_xfer;

   assign csr_ready = 1'b1;

   bams_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // mode state advances exactly once per tick, on the move into the result register
   bams_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .button_c    (in_c_ff),
      .button_z    (in_z_ff),
      .pitch_angle (in_pitch_ff),
      .cfg         (cfg),
      .result      (result)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_c_ff     <= req_button_c;
         in_z_ff     <= req_button_z;
         in_pitch_ff <= req_pitch_angle;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_motor_action       = out_ff.motor_action;
   assign rsp_control_enabled    = out_ff.control_enabled;
   assign rsp_balancing_active   = out_ff.balancing_active;
   assign rsp_arm_ready          = out_ff.arm_ready;
   assign rsp_arm_stage          = out_ff.arm_stage;
   assign rsp_brake_active       = out_ff.brake_active;
   assign rsp_clear_control_vars = out_ff.clear_control_vars;

endmodule

[rtl/core/bams_checker.sv]
module bams_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_motor_action,
   input logic       rsp_control_enabled,
   input logic       rsp_balancing_active,
   input logic       rsp_arm_ready,
   input logic       rsp_arm_stage,
   input logic       rsp_brake_active
);
   import bams_pkg::*;

   // brake while enabled always means brake current
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_control_enabled && rsp_brake_active |-> rsp_motor_action == ACT_BRAKE)
      else $error("enabled brake tick without brake action");

   // disabled control never drives the motors
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_control_enabled |-> rsp_motor_action == ACT_RELEASE)
      else $error("motors driven while control disabled");

   // armed and engaged are exclusive
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_balancing_active |-> !rsp_arm_ready)
      else $error("armed while balancing");

   // second tilt stage only exists while armed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_arm_stage |-> rsp_arm_ready)
      else $error("tilt stage set without arming");

   // stalled result stays valid and keeps its motor action
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_motor_action))
      else $error("stalled result changed");

endmodule

bind balance_arming_mode_sequencer bams_checker u_bams_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_motor_action     (rsp_motor_action),
   .rsp_control_enabled  (rsp_control_enabled),
   .rsp_balancing_active (rsp_balancing_active),
   .rsp_arm_ready        (rsp_arm_ready),
   .rsp_arm_stage        (rsp_arm_stage),
   .rsp_brake_active     (rsp_brake_active)
);
